@@ design/assert_macros.svh @@
// assertion helpers used by sra_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define SRA_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SRA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sra_pkg.sv @@
package sra_pkg;

  localparam int SUM_W  = 48;
  localparam int PROD_W = 32;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // result queue on the output side
  localparam int OUT_DEPTH = 2;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ONLY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDERED_SCAN = 2'd1;

  typedef enum logic [1:0] {
    CMD_ACC,
    CMD_DROP,
    CMD_FLUSH
  } cmd_e;

  typedef enum logic [2:0] {
    B_RUN,
    B_COUNT,
    B_SCAN_RD,
    B_SCAN_EV,
    B_ORD_RD,
    B_ORD_ADR,
    B_ORD_EV,
    B_FINAL
  } back_state_e;

  // pos holds the window offset of an accumulate, the row base of a flush
  typedef struct packed {
    cmd_e                     cmd;
    logic [15:0]              pos;
    logic [6:0]               span;
    logic signed [PROD_W-1:0] prod;
  } item_t;

  typedef struct packed {
    logic [15:0]             column;
    logic signed [SUM_W-1:0] value;
    logic [6:0]              count;
    logic                    present;
    logic                    ovf;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic count_only;
    logic ordered_scan;
  } cfg_t;

endpackage

@@ design/sra_front.sv @@
module sra_front import sra_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic               action_i,
  input  logic [15:0]        column_i,
  input  logic [15:0]        row_min_i,
  input  logic [6:0]         row_span_i,
  input  logic signed [15:0] left_value_i,
  input  logic signed [15:0] right_value_i,
  output item_t              head_o,
  output logic               head_valid_o,
  input  logic               pop_i
);

  logic [16:0]        diff;
  logic               in_win;
  logic signed [PROD_W-1:0] prod;
  item_t              item;

  item_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]    cnt_q, cnt_d;
  logic               push_ok, pop_ok;

  // borrow out means column below the window base
  assign diff   = {1'b0, column_i} - {1'b0, row_min_i};
  assign in_win = !diff[16] && (diff[15:0] < 16'(WINDOW_DEPTH));
  assign prod   = PROD_W'(left_value_i) * PROD_W'(right_value_i);

  always_comb begin
    item.span = row_span_i;
    item.prod = prod;
    if (action_i) begin
      item.cmd = CMD_FLUSH;
      item.pos = row_min_i;
    end else begin
      item.cmd = in_win ? CMD_ACC : CMD_DROP;
      item.pos = diff[15:0];
    end
  end

  assign full_o       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = q_mem[rd_ptr_q];
  assign push_ok      = push_i && !full_o;
  assign pop_ok       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push_ok ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_ok ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_mem[wr_ptr_q] <= item;
    end
  end

endmodule

@@ design/sra_out_fifo.sv @@
module sra_out_fifo import sra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t head_o
);

  res_t              mem [OUT_DEPTH];
  logic [OPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OPTR_W:0]   cnt_q, cnt_d;
  logic              push_ok, pop_ok;

  assign full_o  = (cnt_q == (OPTR_W+1)'(OUT_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign cnt_d   = cnt_q + (OPTR_W+1)'(push_ok) - (OPTR_W+1)'(pop_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= wr_ptr_q + OPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_ptr_q + OPTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ design/sra_back.sv @@
`include "assert_macros.svh"

module sra_back import sra_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  item_t head_i,
  input  logic  head_valid_i,
  output logic  pop_o,
  output logic  res_push_o,
  output res_t  res_o,
  input  logic  res_full_i
);

  localparam int OFF_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  back_state_e state_q, state_d;

  // accumulate write-back stage
  logic                     acc_v_q;
  logic [OFF_W-1:0]         acc_off_q;
  logic signed [PROD_W-1:0] acc_prod_q;
  logic                     fwd_v_q;
  logic [OFF_W-1:0]         fwd_off_q;
  logic signed [SUM_W-1:0]  fwd_sum_q;

  logic [WINDOW_DEPTH-1:0]  valid_q;
  logic [CNT_W-1:0]         touch_cnt_q;
  logic                     ovf_q;

  logic signed [SUM_W-1:0]  sum_mem [WINDOW_DEPTH];
  logic signed [SUM_W-1:0]  sum_rd_q;
  logic [OFF_W-1:0]         touch_mem [WINDOW_DEPTH];
  logic [OFF_W-1:0]         touch_rd_q;

  // flush walk
  logic [15:0]              base_q;
  logic [CNT_W-1:0]         span_q;
  logic [CNT_W-1:0]         idx_q;
  logic [CNT_W-1:0]         n_q;
  logic                     pend_v_q;
  res_t                     pend_q;
  logic [OFF_W-1:0]         emit_off_q;

  logic                     sum_rd_en;
  logic [OFF_W-1:0]         sum_rd_addr;
  logic                     touch_rd_en;
  logic                     start_acc, start_drop, start_flush;
  logic                     idx_inc, cnt_inc, pend_load, emit_off_load, clear_win;

  logic signed [SUM_W-1:0]  old_sum;
  logic signed [SUM_W:0]    acc_wide;
  logic signed [SUM_W-1:0]  new_sum;
  logic                     first_touch;
  logic [CNT_W-1:0]         span_clip;
  logic [OFF_W-1:0]         off_sel;
  logic                     cand;
  logic                     emit_stall;
  res_t                     cand_res;
  res_t                     final_res;

  // ---------------- accumulate datapath ----------------
  always_comb begin
    if (!valid_q[acc_off_q]) begin
      old_sum = '0;
    end else if (fwd_v_q && (fwd_off_q == acc_off_q)) begin
      old_sum = fwd_sum_q;
    end else begin
      old_sum = sum_rd_q;
    end
    acc_wide = (SUM_W+1)'(old_sum) + (SUM_W+1)'(acc_prod_q);
    if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
      new_sum = acc_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      new_sum = acc_wide[SUM_W-1:0];
    end
  end

  assign first_touch = acc_v_q && !valid_q[acc_off_q];

  assign span_clip = (head_i.span > 7'(WINDOW_DEPTH)) ? CNT_W'(WINDOW_DEPTH)
                                                      : CNT_W'(head_i.span);

  // ---------------- flush candidate ----------------
  always_comb begin
    off_sel = (state_q == B_ORD_EV) ? emit_off_q : idx_q[OFF_W-1:0];
    if (state_q == B_ORD_EV) begin
      cand = 1'b1;
    end else begin
      cand = valid_q[idx_q[OFF_W-1:0]] && (sum_rd_q != '0);
    end
    emit_stall = cand && pend_v_q && res_full_i;

    cand_res.column  = base_q + 16'(off_sel);
    cand_res.value   = sum_rd_q;
    cand_res.count   = '0;
    cand_res.present = 1'b1;
    cand_res.ovf     = ovf_q;
    cand_res.last    = 1'b0;

    if (cfg_i.count_only) begin
      final_res.column  = '0;
      final_res.value   = '0;
      final_res.count   = cfg_i.ordered_scan ? 7'(n_q) : 7'(touch_cnt_q);
      final_res.present = 1'b0;
    end else if (pend_v_q) begin
      final_res.column  = pend_q.column;
      final_res.value   = pend_q.value;
      final_res.count   = 7'(n_q);
      final_res.present = 1'b1;
    end else begin
      final_res.column  = '0;
      final_res.value   = '0;
      final_res.count   = '0;
      final_res.present = 1'b0;
    end
    final_res.ovf  = ovf_q;
    final_res.last = 1'b1;
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_RUN: begin
        if (head_valid_i && (head_i.cmd == CMD_FLUSH)) begin
          priority if (cfg_i.count_only && cfg_i.ordered_scan) begin
            state_d = B_COUNT;
          end else if (cfg_i.count_only) begin
            state_d = B_FINAL;
          end else if (cfg_i.ordered_scan) begin
            state_d = B_SCAN_RD;
          end else begin
            state_d = B_ORD_RD;
          end
        end
      end
      B_COUNT:   state_d = (idx_q == span_q) ? B_FINAL : B_COUNT;
      B_SCAN_RD: state_d = (idx_q == span_q) ? B_FINAL : B_SCAN_EV;
      B_SCAN_EV: state_d = emit_stall ? B_SCAN_EV : B_SCAN_RD;
      B_ORD_RD:  state_d = (idx_q == touch_cnt_q) ? B_FINAL : B_ORD_ADR;
      B_ORD_ADR: state_d = B_ORD_EV;
      B_ORD_EV:  state_d = emit_stall ? B_ORD_EV : B_ORD_RD;
      B_FINAL:   state_d = res_full_i ? B_FINAL : B_RUN;
      default:   state_d = B_RUN;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    pop_o         = 1'b0;
    start_acc     = 1'b0;
    start_drop    = 1'b0;
    start_flush   = 1'b0;
    sum_rd_en     = 1'b0;
    sum_rd_addr   = idx_q[OFF_W-1:0];
    touch_rd_en   = 1'b0;
    idx_inc       = 1'b0;
    cnt_inc       = 1'b0;
    pend_load     = 1'b0;
    emit_off_load = 1'b0;
    clear_win     = 1'b0;
    res_push_o    = 1'b0;
    res_o         = pend_q;
    unique case (state_q)
      B_RUN: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          unique case (head_i.cmd)
            CMD_ACC: begin
              start_acc   = 1'b1;
              sum_rd_en   = 1'b1;
              sum_rd_addr = head_i.pos[OFF_W-1:0];
            end
            CMD_DROP:  start_drop  = 1'b1;
            CMD_FLUSH: start_flush = 1'b1;
            default:   start_drop  = 1'b0;
          endcase
        end
      end
      B_COUNT: begin
        if (idx_q != span_q) begin
          idx_inc = 1'b1;
          cnt_inc = valid_q[idx_q[OFF_W-1:0]];
        end
      end
      B_SCAN_RD: begin
        sum_rd_en = (idx_q != span_q);
      end
      B_ORD_RD: begin
        touch_rd_en = (idx_q != touch_cnt_q);
      end
      B_ORD_ADR: begin
        sum_rd_en     = 1'b1;
        sum_rd_addr   = touch_rd_q;
        emit_off_load = 1'b1;
      end
      B_SCAN_EV, B_ORD_EV: begin
        if (!emit_stall) begin
          idx_inc = 1'b1;
          if (cand) begin
            // the held entry goes out once a later one is known
            res_push_o = pend_v_q;
            pend_load  = 1'b1;
            cnt_inc    = 1'b1;
          end
        end
      end
      B_FINAL: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o      = final_res;
          clear_win  = 1'b1;
        end
      end
      default: pop_o = 1'b0;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_RUN;
      acc_v_q     <= 1'b0;
      fwd_v_q     <= 1'b0;
      valid_q     <= '0;
      touch_cnt_q <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_v_q <= start_acc;
      fwd_v_q <= acc_v_q;
      if (clear_win) begin
        valid_q     <= '0;
        touch_cnt_q <= '0;
        ovf_q       <= 1'b0;
      end else begin
        if (acc_v_q) begin
          valid_q[acc_off_q] <= 1'b1;
        end
        if (first_touch && (touch_cnt_q < CNT_W'(WINDOW_DEPTH))) begin
          touch_cnt_q <= touch_cnt_q + CNT_W'(1);
        end
        if (start_drop) begin
          ovf_q <= 1'b1;
        end
      end
      if (start_flush) begin
        idx_q    <= '0;
        n_q      <= '0;
        pend_v_q <= 1'b0;
      end else begin
        if (idx_inc) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (cnt_inc) begin
          n_q <= n_q + CNT_W'(1);
        end
        if (pend_load) begin
          pend_v_q <= 1'b1;
        end
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (start_acc) begin
      acc_off_q  <= head_i.pos[OFF_W-1:0];
      acc_prod_q <= head_i.prod;
    end
    fwd_off_q <= acc_off_q;
    fwd_sum_q <= new_sum;
    if (start_flush) begin
      base_q <= head_i.pos;
      span_q <= span_clip;
    end
    if (pend_load) begin
      pend_q <= cand_res;
    end
    if (emit_off_load) begin
      emit_off_q <= touch_rd_q;
    end
  end

  // sum store: one read and one write port
  always_ff @(posedge clk_i) begin
    if (acc_v_q) begin
      sum_mem[acc_off_q] <= new_sum;
    end
    if (sum_rd_en) begin
      sum_rd_q <= sum_mem[sum_rd_addr];
    end
  end

  // first-touch order store
  always_ff @(posedge clk_i) begin
    if (first_touch && (touch_cnt_q < CNT_W'(WINDOW_DEPTH))) begin
      touch_mem[touch_cnt_q[OFF_W-1:0]] <= acc_off_q;
    end
    if (touch_rd_en) begin
      touch_rd_q <= touch_mem[idx_q[OFF_W-1:0]];
    end
  end

  `SRA_ASSERT(a_touch_bound, clk_i, rst_ni, touch_cnt_q <= CNT_W'(WINDOW_DEPTH), "touch count past window")
  `SRA_ASSERT_IMPL(a_no_pop_in_flush, clk_i, rst_ni, state_q != B_RUN, !pop_o, "request taken during flush")
  `SRA_ASSERT_IMPL(a_push_has_room, clk_i, rst_ni, res_push_o, !res_full_i, "result pushed into full queue")
  `SRA_ASSERT_NEXT(a_flush_drains_acc, clk_i, rst_ni, state_q != B_RUN, !acc_v_q, "accumulate in flight during flush")

endmodule

@@ design/sparse_row_accumulator.sv @@
// accumulate request: registered, then its sum written back; one accepted per cycle outside a flush
// flush: ordered scan reads, then checks each span entry; first-touch reads the order store, then the
//   sum, then checks each touched entry; count-only ordered walks the span's valid bits, count-only
//   unordered goes straight to the result; the walk rate is set by the single read port of the sum
//   and order memories; reset clears the config and all window valid bits at once; no clearing pass needed
module sparse_row_accumulator import sra_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic                 action_i,
  input  logic [15:0]          column_i,
  input  logic [15:0]          row_min_i,
  input  logic [6:0]           row_span_i,
  input  logic signed [15:0]   left_value_i,
  input  logic signed [15:0]   right_value_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [15:0]          out_column_o,
  output logic signed [47:0]   out_value_o,
  output logic [6:0]           entry_count_o,
  output logic                 present_o,
  output logic                 window_overflow_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  cfg_t  cfg_q;
  item_t head;
  logic  head_valid;
  logic  head_pop;
  logic  res_push;
  logic  res_full;
  res_t  res_in;
  res_t  res_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COUNT_ONLY:   cfg_q.count_only   <= cfg_data_i;
        CFG_ORDERED_SCAN: cfg_q.ordered_scan <= cfg_data_i;
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  sra_front #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .action_i     (action_i),
    .column_i     (column_i),
    .row_min_i    (row_min_i),
    .row_span_i   (row_span_i),
    .left_value_i (left_value_i),
    .right_value_i(right_value_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (head_pop)
  );

  sra_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (head_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  sra_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (res_head)
  );

  assign out_column_o      = res_head.column;
  assign out_value_o       = res_head.value;
  assign entry_count_o     = res_head.count;
  assign present_o         = res_head.present;
  assign window_overflow_o = res_head.ovf;
  assign last_o            = res_head.last;

endmodule

@@ tb/sparse_row_accumulator_checker.sv @@
`timescale 1ns / 100ps

module sparse_row_accumulator_checker import sra_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  logic                 action_i,
  input  logic [15:0]          column_i,
  input  logic [15:0]          row_min_i,
  input  logic [6:0]           row_span_i,
  input  logic signed [15:0]   left_value_i,
  input  logic signed [15:0]   right_value_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  input  logic [15:0]          out_column_i,
  input  logic signed [47:0]   out_value_i,
  input  logic [6:0]           entry_count_i,
  input  logic                 present_i,
  input  logic                 window_overflow_i,
  input  logic                 last_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i,
  output int                   mismatch_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  cfg_t                    mode;
  logic signed [SUM_W-1:0] row_sum [WINDOW_DEPTH];
  logic                    row_valid [WINDOW_DEPTH];
  int                      first_touch [WINDOW_DEPTH];
  int                      touched;
  logic                    dropped;
  res_t                    row_results_q [$];
  int                      bad;
  int                      checked;

  function automatic void clear_window();
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      row_sum[i]     = '0;
      row_valid[i]   = 1'b0;
      first_touch[i] = 0;
    end
    touched = 0;
    dropped = 1'b0;
  endfunction

  function automatic void add_product(input logic [15:0] col, input logic [15:0] base,
                                      input logic signed [15:0] lv,
                                      input logic signed [15:0] rv);
    int                       off;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W:0]    wide;
    if (col < base || int'(col - base) >= WINDOW_DEPTH) begin
      dropped = 1'b1;
      return;
    end
    off  = int'(col - base);
    prod = lv * rv;
    wide = row_sum[off];
    wide = wide + prod;
    if (wide > SUM_MAX) wide = SUM_MAX;
    else if (wide < SUM_MIN) wide = SUM_MIN;
    row_sum[off] = wide[SUM_W-1:0];
    if (!row_valid[off]) begin
      row_valid[off] = 1'b1;
      if (touched < WINDOW_DEPTH) begin
        first_touch[touched] = off;
        touched++;
      end
    end
  endfunction

  function automatic void store_result(input logic [15:0] col,
                                       input logic signed [SUM_W-1:0] val,
                                       input logic [6:0] cnt, input logic pres,
                                       input logic fin);
    res_t r;
    r.column  = col;
    r.value   = val;
    r.count   = cnt;
    r.present = pres;
    r.ovf     = dropped;
    r.last    = fin;
    row_results_q.push_back(r);
  endfunction

  function automatic void close_row(input logic [15:0] base, input logic [6:0] span);
    int   lim;
    int   n;
    int   off;
    res_t r;
    lim = (span > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(span);
    n   = 0;
    if (mode.count_only) begin
      if (mode.ordered_scan) begin
        for (int i = 0; i < lim; i++)
          if (row_valid[i]) n++;
      end else begin
        n = touched;
      end
      store_result('0, '0, 7'(n), 1'b0, 1'b1);
    end else begin
      if (mode.ordered_scan) begin
        for (int i = 0; i < lim; i++) begin
          if (row_valid[i] && row_sum[i] != 0) begin
            store_result(base + 16'(i), row_sum[i], '0, 1'b1, 1'b0);
            n++;
          end
        end
      end else begin
        for (int i = 0; i < touched; i++) begin
          off = first_touch[i];
          store_result(base + 16'(off), row_sum[off], '0, 1'b1, 1'b0);
          n++;
        end
      end
      if (n == 0) begin
        store_result('0, '0, '0, 1'b0, 1'b1);
      end else begin
        // count and end mark ride on the final entry of the row
        r = row_results_q.pop_back();
        r.count = 7'(n);
        r.last  = 1'b1;
        row_results_q.push_back(r);
      end
    end
    clear_window();
  endfunction

  function automatic void check_result();
    res_t want;
    res_t got;
    got.column  = out_column_i;
    got.value   = out_value_i;
    got.count   = entry_count_i;
    got.present = present_i;
    got.ovf     = window_overflow_i;
    got.last    = last_i;
    if (row_results_q.size() == 0) begin
      bad++;
      if (bad <= 10)
        $display("%0t: result with nothing expected: col %h val %h cnt %0d last %b",
                 $realtime, got.column, got.value, got.count, got.last);
      return;
    end
    want = row_results_q.pop_front();
    checked++;
    if (got !== want) begin
      bad++;
      if (bad <= 10) begin
        $display("%0t: mismatch on result %0d", $realtime, checked);
        $display("  expected col %h val %h cnt %0d present %b ovf %b last %b",
                 want.column, want.value, want.count, want.present, want.ovf, want.last);
        $display("  actual   col %h val %h cnt %0d present %b ovf %b last %b",
                 got.column, got.value, got.count, got.present, got.ovf, got.last);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode = '0;
      clear_window();
      row_results_q.delete();
      bad     = 0;
      checked = 0;
    end else begin
      // a result leaving now always belongs to an earlier request
      if (pop_i && !empty_i) check_result();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_COUNT_ONLY:   mode.count_only   = cfg_data_i;
          CFG_ORDERED_SCAN: mode.ordered_scan = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        if (action_i) close_row(row_min_i, row_span_i);
        else add_product(column_i, row_min_i, left_value_i, right_value_i);
      end
    end
    mismatch_count_o <= bad;
    pending_o        <= row_results_q.size();
    checked_o        <= checked;
  end

endmodule

@@ tb/sparse_row_accumulator_tb.sv @@
`timescale 1ns / 100ps

module sparse_row_accumulator_tb;
  import sra_pkg::*;

  localparam int WINDOW_DEPTH  = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int PEAK_PAIRS    = 4;
  localparam int TIMEOUT_NS    = 1_000_000;

  localparam logic ACT_ACCUMULATE = 1'b0;
  localparam logic ACT_FLUSH      = 1'b1;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic                 action_i;
  logic [15:0]          column_i;
  logic [15:0]          row_min_i;
  logic [6:0]           row_span_i;
  logic signed [15:0]   left_value_i;
  logic signed [15:0]   right_value_i;
  logic                 empty;
  logic                 pop;
  logic [15:0]          out_column_o;
  logic signed [47:0]   out_value_o;
  logic [6:0]           entry_count_o;
  logic                 present_o;
  logic                 window_overflow_o;
  logic                 last_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic                 cfg_data_i;

  int mismatches;
  int pending;
  int checked;
  int send_idle;
  int recv_stall;
  int hold_left;
  int sent_count;
  int flush_count;

  sparse_row_accumulator #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .action_i         (action_i),
    .column_i         (column_i),
    .row_min_i        (row_min_i),
    .row_span_i       (row_span_i),
    .left_value_i     (left_value_i),
    .right_value_i    (right_value_i),
    .empty            (empty),
    .pop              (pop),
    .out_column_o     (out_column_o),
    .out_value_o      (out_value_o),
    .entry_count_o    (entry_count_o),
    .present_o        (present_o),
    .window_overflow_o(window_overflow_o),
    .last_o           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  sparse_row_accumulator_checker #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .action_i         (action_i),
    .column_i         (column_i),
    .row_min_i        (row_min_i),
    .row_span_i       (row_span_i),
    .left_value_i     (left_value_i),
    .right_value_i    (right_value_i),
    .empty_i          (empty),
    .pop_i            (pop),
    .out_column_i     (out_column_o),
    .out_value_i      (out_value_o),
    .entry_count_i    (entry_count_o),
    .present_i        (present_o),
    .window_overflow_i(window_overflow_o),
    .last_i           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results still expected", pending);
    $display("sparse_row_accumulator_tb failed");
    $finish;
  end

  // result side: random stalls, or a long hold-off counted down here
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic send_req(input logic act, input logic [15:0] col, input logic [15:0] base,
                          input logic [6:0] span, input logic [15:0] lv,
                          input logic [15:0] rv);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push          <= 1'b1;
    action_i      <= act;
    column_i      <= col;
    row_min_i     <= base;
    row_span_i    <= span;
    left_value_i  <= lv;
    right_value_i <= rv;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_count++;
    if (act == ACT_FLUSH) flush_count++;
  endtask

  task automatic push_product(input logic [15:0] col, input logic [15:0] base,
                              input logic [15:0] lv, input logic [15:0] rv);
    send_req(ACT_ACCUMULATE, col, base, 7'($urandom), lv, rv);
  endtask

  task automatic close_row(input logic [15:0] base, input logic [6:0] span);
    send_req(ACT_FLUSH, 16'($urandom), base, span, 16'($urandom), 16'($urandom));
  endtask

  // stop offering and wait until every expected result is out
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic count_only, input logic ordered);
    settle();
    write_cfg(CFG_COUNT_ONLY, count_only);
    write_cfg(CFG_ORDERED_SCAN, ordered);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_row(input int max_prod);
    logic [15:0] base;
    logic [15:0] col;
    logic [15:0] lv;
    logic [15:0] rv;
    logic [6:0]  span;
    int          n;
    case ($urandom_range(9))
      0:       base = 16'h0000;
      1:       base = 16'hFFFF - 16'($urandom_range(WINDOW_DEPTH - 1));
      2:       base = 16'hFFFF;
      default: base = 16'($urandom);
    endcase
    n = ($urandom_range(9) == 0) ? $urandom_range(max_prod) : $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(11))
        0:       col = 16'($urandom);
        1:       col = base - 16'd1;
        2:       col = base + 16'(WINDOW_DEPTH);
        // a few low offsets get hit repeatedly so sums build up
        3, 4, 5: col = base + 16'($urandom_range(7));
        default: col = base + 16'($urandom_range(WINDOW_DEPTH - 1));
      endcase
      lv = pick_operand();
      rv = pick_operand();
      push_product(col, base, lv, rv);
      // cancel the product again to leave a touched entry at zero
      if ($urandom_range(7) == 0 && lv != 16'h8000) push_product(col, base, -lv, rv);
    end
    case ($urandom_range(5))
      0:       span = 7'd0;
      1:       span = 7'(WINDOW_DEPTH);
      2:       span = 7'd127;
      3:       span = 7'($urandom_range(WINDOW_DEPTH + 1, 127));
      default: span = 7'($urandom_range(1, WINDOW_DEPTH));
    endcase
    close_row(($urandom_range(9) == 0) ? 16'($urandom) : base, span);
  endtask

  // touches every window entry once, in shuffled order
  task automatic full_window_row(input logic [15:0] base);
    int perm [WINDOW_DEPTH];
    int j;
    int tmp;
    for (int i = 0; i < WINDOW_DEPTH; i++) perm[i] = i;
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < WINDOW_DEPTH; i++)
      push_product(base + 16'(perm[i]), base, pick_operand(), pick_operand());
    close_row(base, ($urandom_range(1) != 0) ? 7'(WINDOW_DEPTH) : 7'd127);
  endtask

  task automatic run_phase(input logic count_only, input logic ordered, input int si,
                           input int rs, input int rows, input bit big);
    set_mode(count_only, ordered);
    send_idle  = si;
    recv_stall = rs;
    if (big) full_window_row(16'($urandom_range(16'hFFFF - WINDOW_DEPTH + 1)));
    repeat (rows) random_row(40);
  endtask

  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    action_i      = ACT_ACCUMULATE;
    column_i      = '0;
    row_min_i     = '0;
    row_span_i    = '0;
    left_value_i  = '0;
    right_value_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_COUNT_ONLY;
    cfg_data_i    = 1'b0;
    send_idle     = 0;
    recv_stall    = 0;
    hold_left     = 0;
    sent_count    = 0;
    flush_count   = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // first-touch mode straight out of reset
    close_row(16'h0000, 7'(WINDOW_DEPTH));                // nothing touched
    push_product(16'd0, 16'd0, 16'h7FFF, 16'h7FFF);
    push_product(16'd0, 16'd0, 16'h8000, 16'h8000);
    push_product(16'd63, 16'd0, 16'h8000, 16'h7FFF);
    push_product(16'd64, 16'd0, 16'h0001, 16'h0001);      // one past the window
    push_product(16'd7, 16'd0, 16'h0000, 16'h1234);       // touched, zero sum
    close_row(16'd0, 7'd127);
    push_product(16'd5, 16'd10, 16'h0100, 16'h0100);      // below the window base
    push_product(16'hFFFF, 16'hFFC0, 16'hFFFF, 16'h8000);
    push_product(16'hFFC0, 16'hFFC0, 16'h7FFF, 16'hFFFF);
    close_row(16'hFFFF, 7'd0);                            // new base, columns wrap

    set_mode(1'b0, 1'b1);
    push_product(16'd3, 16'd0, 16'h0200, 16'hFF00);
    push_product(16'd1, 16'd0, 16'h0000, 16'h7FFF);
    push_product(16'd40, 16'd0, 16'h0100, 16'h0100);      // past the scan span
    close_row(16'd0, 7'd16);
    push_product(16'd2, 16'd0, 16'h0000, 16'h0000);
    close_row(16'd0, 7'(WINDOW_DEPTH));                   // only a zero sum left

    set_mode(1'b1, 1'b0);
    push_product(16'd10, 16'd8, 16'h0100, 16'h0300);
    push_product(16'd10, 16'd8, 16'h0100, 16'hFD00);
    push_product(16'd12, 16'd8, 16'h8000, 16'h0001);
    close_row(16'd8, 7'(WINDOW_DEPTH));

    set_mode(1'b1, 1'b1);
    push_product(16'd2, 16'd0, 16'h0400, 16'h0400);
    push_product(16'd50, 16'd0, 16'h0400, 16'h0400);
    close_row(16'd0, 7'd10);

    // writes to unused indexes must not disturb the mode
    settle();
    write_cfg(CFG_SPARE_LO, 1'b1);
    write_cfg(CFG_SPARE_HI, 1'b0);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;

    // largest products of both signs pile up on two entries of one row
    set_mode(1'b0, 1'b0);
    for (int i = 0; i < PEAK_PAIRS; i++) begin
      push_product(16'h1234, 16'h1234, 16'h8000, 16'h8000);
      push_product(16'h1235, 16'h1234, 16'h8000, 16'h7FFF);
    end
    push_product(16'h1234, 16'h1234, 16'hFFFF, 16'h0001);  // one small step back
    close_row(16'h1234, 7'(WINDOW_DEPTH));

    run_phase(1'b0, 1'b0, 0, 0, 3, 1'b1);
    run_phase(1'b0, 1'b1, 75, 0, 3, 1'b0);
    run_phase(1'b1, 1'b0, 0, 75, 3, 1'b0);
    run_phase(1'b1, 1'b1, 23, 23, 3, 1'b0);

    // result side held off while requests keep coming, so the block backs up
    set_mode(1'b0, 1'b0);
    send_idle  = 0;
    recv_stall = 0;
    hold_left  = HOLD_CYCLES;
    full_window_row(16'($urandom_range(16'hFFFF - WINDOW_DEPTH + 1)));
    repeat (4) random_row(20);
    settle();

    run_phase(1'b0, 1'b1, 23, 23, 3, 1'b0);
    run_phase(1'b1, 1'b1, 0, 75, 3, 1'b0);
    run_phase(1'b0, 1'b0, 75, 75, 3, 1'b0);

    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (%0d row flushes) and checked %0d results in all four modes",
             sent_count, flush_count, checked);
    $display("with no idling, slow sender, slow receiver, both, a long hold-off and peak products");
    if (mismatches == 0 && pending == 0) begin
      $display("sparse_row_accumulator_tb passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, pending);
      $display("sparse_row_accumulator_tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/sra_pkg.sv
design/sra_front.sv
design/sra_out_fifo.sv
design/sra_back.sv
design/sparse_row_accumulator.sv
tb/sparse_row_accumulator_checker.sv
tb/sparse_row_accumulator_tb.sv
